/* hdl/bmtd_pkg.sv */
// Package for the bicycle model tire dynamics step block.
// Fixed-point constants, the Q.24 saturating helpers, the arctangent table
// and the microcode program. No dependencies.
package bmtd_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int STATE_FRAC_BITS = 16;
  localparam int WF              = 24;
  localparam int SHIFT           = WF - STATE_FRAC_BITS;
  localparam int CNT_W           = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int ACCEL_W    = 24;
  localparam int STEER_W    = 18;
  localparam int FRIC_W     = 18;
  localparam int SPEED_W    = 32;

  typedef logic signed [63:0] w_t;

  localparam w_t WLIM      = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam w_t WONE      = 64'sd16777216;
  localparam w_t GRAV_W    = 64'sd164752261;
  localparam w_t PI_W      = 64'sd52707179;
  localparam w_t HALF_PI_W = 64'sd26353589;
  localparam w_t TWO_PI_W  = 64'sd105414357;
  localparam w_t KINV_W    = 64'sd10188013;
  localparam w_t SLOW_W    = 64'sd1678;
  localparam w_t LIFT_W    = 64'sd167772;
  localparam w_t RESTART_W = 64'sd1677722;
  localparam w_t RND_HALF  = w_t'((64'd1 << SHIFT) >> 1);
  localparam w_t I32_MAX   = 64'sd2147483647;
  localparam w_t I32_MIN   = -64'sd2147483648;

  localparam logic signed [64:0] WLIM65  = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] NWLIM65 = -WLIM65;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MASS, CFG_INERTIA, CFG_WHEELBASE, CFG_FRONT,
    CFG_STIFF, CFG_SHAPE, CFG_CURV, CFG_DT
  } cfg_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ATAN, OP_SINCOS, OP_RND, OP_END
  } op_e;

  typedef enum logic [5:0] {
    SRC_ZERO, SRC_WONE, SRC_GRAV, SRC_ACCEL, SRC_STEER, SRC_MU, SRC_M, SRC_IZ,
    SRC_LEN, SRC_LF, SRC_LR, SRC_CF, SRC_EF, SRC_CST, SRC_DT, SRC_VX,
    SRC_VY, SRC_R, SRC_T0, SRC_T1, SRC_SLF, SRC_SLR, SRC_FZF, SRC_FZR,
    SRC_D, SRC_BA, SRC_FF, SRC_FR, SRC_FFC, SRC_SIN, SRC_COS, SRC_DVX,
    SRC_DVY, SRC_DR
  } src_e;

  localparam int NUM_SRC = 34;

  typedef enum logic [4:0] {
    DST_NONE, DST_VX, DST_VY, DST_R, DST_T0, DST_T1, DST_SLF, DST_SLR,
    DST_FZF, DST_FZR, DST_D, DST_BA, DST_FF, DST_FR, DST_FFC, DST_DVX,
    DST_DVY, DST_DR, DST_VXS, DST_VYS, DST_RS
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e d;
  } uc_t;

  localparam int PROG_LEN = 62;
  localparam int PC_W     = $clog2(PROG_LEN);

  // request / response between sequencer and the shared units
  typedef struct packed {
    logic start;
    w_t   a;
    w_t   b;
  } ar_req_t;

  typedef struct packed {
    logic done;
    w_t   res;
  } ar_rsp_t;

  typedef struct packed {
    logic start;
    logic rot;
    w_t   a;
    w_t   b;
  } cor_req_t;

  typedef struct packed {
    logic done;
    w_t   r0;
    w_t   r1;
  } cor_rsp_t;

  function automatic logic [63:0] f_mag(w_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic w_t f_add(w_t a, w_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > WLIM65) return WLIM;
    if (s < NWLIM65) return -WLIM;
    return s[63:0];
  endfunction

  function automatic w_t f_atan_tab(logic [4:0] i);
    case (i)
      5'd0:    return 64'sd13176795;
      5'd1:    return 64'sd7778716;
      5'd2:    return 64'sd4110060;
      5'd3:    return 64'sd2086331;
      5'd4:    return 64'sd1047214;
      5'd5:    return 64'sd524117;
      5'd6:    return 64'sd262123;
      5'd7:    return 64'sd131069;
      5'd8:    return 64'sd65536;
      5'd9:    return 64'sd32768;
      5'd10:   return 64'sd16384;
      5'd11:   return 64'sd8192;
      5'd12:   return 64'sd4096;
      5'd13:   return 64'sd2048;
      5'd14:   return 64'sd1024;
      5'd15:   return 64'sd512;
      5'd16:   return 64'sd256;
      5'd17:   return 64'sd128;
      5'd18:   return 64'sd64;
      5'd19:   return 64'sd32;
      5'd20:   return 64'sd16;
      5'd21:   return 64'sd8;
      5'd22:   return 64'sd4;
      5'd23:   return 64'sd2;
      5'd24:   return 64'sd1;
      default: return 64'sd0;
    endcase
  endfunction

  function automatic uc_t f_mk(op_e o, src_e a, src_e b, dst_e d);
    uc_t u;
    u.op = o;
    u.a  = a;
    u.b  = b;
    u.d  = d;
    return u;
  endfunction

  function automatic uc_t f_uc(logic [PC_W-1:0] pc);
    case (pc)
      // slip angles
      6'd0:  return f_mk(OP_MUL, SRC_LF, SRC_R, DST_T0);
      6'd1:  return f_mk(OP_ADD, SRC_VY, SRC_T0, DST_T0);
      6'd2:  return f_mk(OP_ATAN, SRC_T0, SRC_VX, DST_T0);
      6'd3:  return f_mk(OP_SUB, SRC_STEER, SRC_T0, DST_SLF);
      6'd4:  return f_mk(OP_MUL, SRC_LR, SRC_R, DST_T0);
      6'd5:  return f_mk(OP_SUB, SRC_VY, SRC_T0, DST_T0);
      6'd6:  return f_mk(OP_ATAN, SRC_T0, SRC_VX, DST_T0);
      6'd7:  return f_mk(OP_SUB, SRC_ZERO, SRC_T0, DST_SLR);
      // axle loads
      6'd8:  return f_mk(OP_MUL, SRC_M, SRC_GRAV, DST_T1);
      6'd9:  return f_mk(OP_MUL, SRC_T1, SRC_LR, DST_T0);
      6'd10: return f_mk(OP_DIV, SRC_T0, SRC_LEN, DST_FZF);
      6'd11: return f_mk(OP_MUL, SRC_T1, SRC_LF, DST_T0);
      6'd12: return f_mk(OP_DIV, SRC_T0, SRC_LEN, DST_FZR);
      // front tire
      6'd13: return f_mk(OP_MUL, SRC_MU, SRC_FZF, DST_D);
      6'd14: return f_mk(OP_MUL, SRC_CF, SRC_D, DST_T0);
      6'd15: return f_mk(OP_DIV, SRC_CST, SRC_T0, DST_T0);
      6'd16: return f_mk(OP_MUL, SRC_T0, SRC_SLF, DST_BA);
      6'd17: return f_mk(OP_ATAN, SRC_BA, SRC_WONE, DST_T0);
      6'd18: return f_mk(OP_SUB, SRC_BA, SRC_T0, DST_T0);
      6'd19: return f_mk(OP_MUL, SRC_EF, SRC_T0, DST_T0);
      6'd20: return f_mk(OP_SUB, SRC_BA, SRC_T0, DST_T0);
      6'd21: return f_mk(OP_ATAN, SRC_T0, SRC_WONE, DST_T0);
      6'd22: return f_mk(OP_MUL, SRC_CF, SRC_T0, DST_T0);
      6'd23: return f_mk(OP_SINCOS, SRC_T0, SRC_ZERO, DST_NONE);
      6'd24: return f_mk(OP_MUL, SRC_D, SRC_SIN, DST_FF);
      // rear tire
      6'd25: return f_mk(OP_MUL, SRC_MU, SRC_FZR, DST_D);
      6'd26: return f_mk(OP_MUL, SRC_CF, SRC_D, DST_T0);
      6'd27: return f_mk(OP_DIV, SRC_CST, SRC_T0, DST_T0);
      6'd28: return f_mk(OP_MUL, SRC_T0, SRC_SLR, DST_BA);
      6'd29: return f_mk(OP_ATAN, SRC_BA, SRC_WONE, DST_T0);
      6'd30: return f_mk(OP_SUB, SRC_BA, SRC_T0, DST_T0);
      6'd31: return f_mk(OP_MUL, SRC_EF, SRC_T0, DST_T0);
      6'd32: return f_mk(OP_SUB, SRC_BA, SRC_T0, DST_T0);
      6'd33: return f_mk(OP_ATAN, SRC_T0, SRC_WONE, DST_T0);
      6'd34: return f_mk(OP_MUL, SRC_CF, SRC_T0, DST_T0);
      6'd35: return f_mk(OP_SINCOS, SRC_T0, SRC_ZERO, DST_NONE);
      6'd36: return f_mk(OP_MUL, SRC_D, SRC_SIN, DST_FR);
      // derivatives
      6'd37: return f_mk(OP_SINCOS, SRC_STEER, SRC_ZERO, DST_NONE);
      6'd38: return f_mk(OP_MUL, SRC_FF, SRC_COS, DST_FFC);
      6'd39: return f_mk(OP_MUL, SRC_FF, SRC_SIN, DST_T0);
      6'd40: return f_mk(OP_DIV, SRC_T0, SRC_M, DST_T0);
      6'd41: return f_mk(OP_SUB, SRC_ACCEL, SRC_T0, DST_T0);
      6'd42: return f_mk(OP_MUL, SRC_R, SRC_VY, DST_T1);
      6'd43: return f_mk(OP_ADD, SRC_T0, SRC_T1, DST_DVX);
      6'd44: return f_mk(OP_ADD, SRC_FFC, SRC_FR, DST_T0);
      6'd45: return f_mk(OP_DIV, SRC_T0, SRC_M, DST_T0);
      6'd46: return f_mk(OP_MUL, SRC_R, SRC_VX, DST_T1);
      6'd47: return f_mk(OP_SUB, SRC_T0, SRC_T1, DST_DVY);
      6'd48: return f_mk(OP_MUL, SRC_LF, SRC_FFC, DST_T0);
      6'd49: return f_mk(OP_MUL, SRC_LR, SRC_FR, DST_T1);
      6'd50: return f_mk(OP_SUB, SRC_T0, SRC_T1, DST_T0);
      6'd51: return f_mk(OP_DIV, SRC_T0, SRC_IZ, DST_DR);
      // Euler update and rounding to state format
      6'd52: return f_mk(OP_MUL, SRC_DVX, SRC_DT, DST_T0);
      6'd53: return f_mk(OP_ADD, SRC_VX, SRC_T0, DST_VX);
      6'd54: return f_mk(OP_MUL, SRC_DVY, SRC_DT, DST_T0);
      6'd55: return f_mk(OP_ADD, SRC_VY, SRC_T0, DST_VY);
      6'd56: return f_mk(OP_MUL, SRC_DR, SRC_DT, DST_T0);
      6'd57: return f_mk(OP_ADD, SRC_R, SRC_T0, DST_R);
      6'd58: return f_mk(OP_RND, SRC_VX, SRC_ZERO, DST_VXS);
      6'd59: return f_mk(OP_RND, SRC_VY, SRC_ZERO, DST_VYS);
      6'd60: return f_mk(OP_RND, SRC_R, SRC_ZERO, DST_RS);
      default: return f_mk(OP_END, SRC_ZERO, SRC_ZERO, DST_NONE);
    endcase
  endfunction

endpackage

/* hdl/bmtd_if.sv */
// Valid/ready channel interfaces for the input item and the result item.
// Depends on bmtd_pkg for field widths.
interface bmtd_in_if import bmtd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ACCEL_W-1:0]  accel_cmd;
  logic signed [STEER_W-1:0]  steer_angle;
  logic        [FRIC_W-1:0]   friction;
  logic                       restart;

  modport source (output valid, accel_cmd, steer_angle, friction, restart, input ready);
  modport sink   (input valid, accel_cmd, steer_angle, friction, restart, output ready);
endinterface

interface bmtd_out_if import bmtd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SPEED_W-1:0]  long_speed;
  logic signed [SPEED_W-1:0]  lat_speed;
  logic signed [SPEED_W-1:0]  yaw_speed;

  modport source (output valid, long_speed, lat_speed, yaw_speed, input ready);
  modport sink   (input valid, long_speed, lat_speed, yaw_speed, output ready);
endinterface

/* hdl/bmtd_mul.sv */
// Shared Q.24 saturating multiplier, one 32x32 partial product per cycle.
// Depends on bmtd_pkg.
module bmtd_mul import bmtd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ar_req_t req_i,
  output ar_rsp_t rsp_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_e;

  mstate_e       state_q;
  logic [1:0]    k_q;
  logic [63:0]   am_q, bm_q;
  logic          neg_q;
  logic [127:0]  acc_q;
  logic          done_q;
  w_t            res_q;

  logic [31:0]   pa, pb;
  logic [63:0]   pp;
  logic [127:0]  pp_sh;
  logic [63:0]   mres;

  always_comb begin
    pa = k_q[0] ? am_q[63:32] : am_q[31:0];
    pb = k_q[1] ? bm_q[63:32] : bm_q[31:0];
    pp = pa * pb;
    case (k_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    if (acc_q[127:88] != '0 || acc_q[87:86] != '0) begin
      mres = 64'(WLIM);
    end else begin
      mres = acc_q[87:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      k_q     <= '0;
      am_q    <= '0;
      bm_q    <= '0;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            am_q    <= f_mag(req_i.a);
            bm_q    <= f_mag(req_i.b);
            neg_q   <= req_i.a[63] ^ req_i.b[63];
            acc_q   <= '0;
            k_q     <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          acc_q <= acc_q + pp_sh;
          k_q   <= k_q + 2'd1;
          if (k_q == 2'd3) state_q <= M_FIN;
        end
        M_FIN: begin
          res_q   <= neg_q ? -w_t'(mres) : w_t'(mres);
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* hdl/bmtd_div.sv */
// Shared Q.24 saturating divider, restoring, one quotient bit per cycle.
// Depends on bmtd_pkg.
module bmtd_div import bmtd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ar_req_t req_i,
  output ar_rsp_t rsp_o
);

  localparam int NB = 64 + WF;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e            state_q;
  logic [NB-1:0]      n_q;
  logic [NB-1:0]      q_q;
  logic [63:0]        b_q;
  logic [63:0]        r_q;
  logic [6:0]         cnt_q;
  logic               neg_q;
  logic               bz_q;
  logic               done_q;
  w_t                 res_q;

  logic [64:0]        r_sh;
  logic               ge;
  logic [63:0]        qm;

  always_comb begin
    r_sh = {r_q, n_q[NB-1]};
    ge   = (r_sh >= {1'b0, b_q});
    if (bz_q) begin
      qm = '0;
    end else if (q_q[NB-1:62] != '0) begin
      qm = 64'(WLIM);
    end else begin
      qm = q_q[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      n_q     <= '0;
      q_q     <= '0;
      b_q     <= '0;
      r_q     <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      bz_q    <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            n_q     <= {f_mag(req_i.a), {WF{1'b0}}};
            b_q     <= f_mag(req_i.b);
            neg_q   <= req_i.a[63] ^ req_i.b[63];
            bz_q    <= (req_i.b == '0);
            r_q     <= '0;
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= (req_i.b == '0) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          r_q   <= ge ? 64'(r_sh - {1'b0, b_q}) : r_sh[63:0];
          q_q   <= {q_q[NB-2:0], ge};
          n_q   <= {n_q[NB-2:0], 1'b0};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(NB - 1)) state_q <= D_FIN;
        end
        D_FIN: begin
          res_q   <= neg_q ? -w_t'(qm) : w_t'(qm);
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* hdl/bmtd_cordic.sv */
// Shared CORDIC unit: vectoring arctangent with input normalization, and
// rotation sine/cosine with 2*pi range reduction. Depends on bmtd_pkg.
module bmtd_cordic import bmtd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  typedef enum logic [2:0] {C_IDLE, C_NORM, C_RED, C_FOLD, C_ITER, C_FIN} cstate_e;

  cstate_e          state_q;
  w_t               x_q, y_q, z_q;
  logic [63:0]      zm_q;
  logic             neg_q;
  logic             rot_q;
  logic             flip_q;
  logic [CNT_W-1:0] i_q;
  logic             done_q;
  w_t               r0_q, r1_q;

  w_t   xs, ys, tab, zz, zf;
  logic pos, big, ffl;

  always_comb begin
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    tab = f_atan_tab(5'(i_q));
    pos = rot_q ? !z_q[63] : !y_q[63];
    big = (x_q[63:40] != '0) || (f_mag(y_q) >= 64'h100_0000_0000);
    // fold reduced angle into [-pi/2, pi/2]
    zz  = neg_q ? -w_t'(zm_q) : w_t'(zm_q);
    if (zz > PI_W) zz = zz - TWO_PI_W;
    if (zz < -PI_W) zz = zz + TWO_PI_W;
    ffl = 1'b0;
    zf  = zz;
    if (zz > HALF_PI_W) begin
      zf  = PI_W - zz;
      ffl = 1'b1;
    end else if (zz < -HALF_PI_W) begin
      zf  = -PI_W - zz;
      ffl = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      zm_q    <= '0;
      neg_q   <= 1'b0;
      rot_q   <= 1'b0;
      flip_q  <= 1'b0;
      i_q     <= '0;
      done_q  <= 1'b0;
      r0_q    <= '0;
      r1_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            rot_q  <= req_i.rot;
            flip_q <= 1'b0;
            z_q    <= '0;
            if (req_i.rot) begin
              zm_q    <= f_mag(req_i.a);
              neg_q   <= req_i.a[63];
              state_q <= C_RED;
            end else begin
              x_q     <= req_i.b;
              y_q     <= req_i.a;
              // zero argument gives an exact zero angle
              state_q <= (req_i.a == '0) ? C_FIN : C_NORM;
            end
          end
        end
        C_NORM: begin
          if (big) begin
            x_q <= x_q >>> 1;
            y_q <= y_q >>> 1;
          end else begin
            i_q     <= '0;
            state_q <= C_ITER;
          end
        end
        C_RED: begin
          if (zm_q >= 64'(TWO_PI_W)) begin
            zm_q <= zm_q - 64'(TWO_PI_W);
          end else begin
            state_q <= C_FOLD;
          end
        end
        C_FOLD: begin
          x_q     <= KINV_W;
          y_q     <= '0;
          z_q     <= zf;
          flip_q  <= ffl;
          i_q     <= '0;
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (rot_q) begin
            x_q <= pos ? x_q - ys : x_q + ys;
            y_q <= pos ? y_q + xs : y_q - xs;
            z_q <= pos ? z_q - tab : z_q + tab;
          end else begin
            x_q <= pos ? x_q + ys : x_q - ys;
            y_q <= pos ? y_q - xs : y_q + xs;
            z_q <= pos ? z_q + tab : z_q - tab;
          end
          i_q <= i_q + 1'b1;
          if (i_q == CNT_W'(CORDIC_STEPS - 1)) state_q <= C_FIN;
        end
        C_FIN: begin
          r0_q    <= rot_q ? y_q : z_q;
          r1_q    <= flip_q ? -x_q : x_q;
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r0   = r0_q;
  assign rsp_o.r1   = r1_q;

endmodule

/* hdl/bicycle_model_tire_dynamics_step.sv */
// Item time is set by the shared units: each item runs seven 88-step divisions,
// twenty-six multiplies and nine CORDIC runs, and does each add and round in the
// sequencer itself.
// Throughput: one item at a time, input not ready until the result is queued.
// The result register lets the next item start while a result waits.
// Reset: speeds clear to zero, registers load their defaults, no clearing pass.
module bicycle_model_tire_dynamics_step import bmtd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bmtd_in_if.sink               in_i,
  bmtd_out_if.source            out_o
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} sstate_e;

  // configuration
  logic [23:0]        mass_q, inertia_q, dt_q;
  logic [19:0]        wb_q, lf_q, shape_q;
  logic [27:0]        stiff_q;
  logic signed [20:0] curv_q;

  sstate_e            state_q;
  logic [PC_W-1:0]    pc_q;
  logic signed [31:0] vxs_q, vys_q, rs_q;
  logic signed [31:0] ovx_q, ovy_q, or_q;
  logic               out_valid_q;

  w_t accel_q, steer_q, mu_q;
  w_t vx_q, vy_q, r_q, t0_q, t1_q, slf_q, slr_q, fzf_q, fzr_q;
  w_t d_q, ba_q, ff_q, fr_q, ffc_q, sin_q, cos_q, dvx_q, dvy_q, dr_q;

  uc_t      uc;
  w_t       src_v [NUM_SRC];
  w_t       opa, opb, alu, rnd_w, wval, unit_res;
  logic signed [31:0] rnd32;
  logic     unit_done, wr_en;
  w_t       len_w, lf_w, vx_init, vy_init, r_init, acc_init, str_init;
  ar_req_t  mul_req, div_req;
  ar_rsp_t  mul_rsp, div_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  assign uc    = f_uc(pc_q);
  assign len_w = {36'd0, wb_q, 8'd0};
  assign lf_w  = {36'd0, lf_q, 8'd0};

  always_comb begin
    src_v[SRC_ZERO]  = '0;
    src_v[SRC_WONE]  = WONE;
    src_v[SRC_GRAV]  = GRAV_W;
    src_v[SRC_ACCEL] = accel_q;
    src_v[SRC_STEER] = steer_q;
    src_v[SRC_MU]    = mu_q;
    src_v[SRC_M]     = {24'd0, mass_q, 16'd0};
    src_v[SRC_IZ]    = {24'd0, inertia_q, 16'd0};
    src_v[SRC_LEN]   = len_w;
    src_v[SRC_LF]    = lf_w;
    src_v[SRC_LR]    = len_w - lf_w;
    src_v[SRC_CF]    = {36'd0, shape_q, 8'd0};
    src_v[SRC_EF]    = {{35{curv_q[20]}}, curv_q, 8'd0};
    src_v[SRC_CST]   = {20'd0, stiff_q, 16'd0};
    src_v[SRC_DT]    = {40'd0, dt_q};
    src_v[SRC_VX]    = vx_q;
    src_v[SRC_VY]    = vy_q;
    src_v[SRC_R]     = r_q;
    src_v[SRC_T0]    = t0_q;
    src_v[SRC_T1]    = t1_q;
    src_v[SRC_SLF]   = slf_q;
    src_v[SRC_SLR]   = slr_q;
    src_v[SRC_FZF]   = fzf_q;
    src_v[SRC_FZR]   = fzr_q;
    src_v[SRC_D]     = d_q;
    src_v[SRC_BA]    = ba_q;
    src_v[SRC_FF]    = ff_q;
    src_v[SRC_FR]    = fr_q;
    src_v[SRC_FFC]   = ffc_q;
    src_v[SRC_SIN]   = sin_q;
    src_v[SRC_COS]   = cos_q;
    src_v[SRC_DVX]   = dvx_q;
    src_v[SRC_DVY]   = dvy_q;
    src_v[SRC_DR]    = dr_q;
    opa = src_v[uc.a];
    opb = src_v[uc.b];
  end

  // add/sub/round are done in the sequencer itself
  always_comb begin
    alu   = (uc.op == OP_SUB) ? f_add(opa, -opb) : f_add(opa, opb);
    rnd_w = f_add(opa, RND_HALF) >>> SHIFT;
    if (rnd_w > I32_MAX) begin
      rnd32 = 32'sh7FFF_FFFF;
    end else if (rnd_w < I32_MIN) begin
      rnd32 = -32'sh8000_0000;
    end else begin
      rnd32 = rnd_w[31:0];
    end
    case (uc.op)
      OP_MUL:  begin unit_res = mul_rsp.res; unit_done = mul_rsp.done; end
      OP_DIV:  begin unit_res = div_rsp.res; unit_done = div_rsp.done; end
      default: begin unit_res = cor_rsp.r0;  unit_done = cor_rsp.done; end
    endcase
    wr_en = 1'b0;
    wval  = alu;
    if (state_q == S_ISSUE && (uc.op == OP_ADD || uc.op == OP_SUB)) begin
      wr_en = 1'b1;
    end else if (state_q == S_WAIT && unit_done) begin
      wr_en = 1'b1;
      wval  = unit_res;
    end
  end

  // speeds on entry: slow lift, then restart override
  always_comb begin
    vx_init  = {{32{vxs_q[31]}}, vxs_q} << SHIFT;
    vy_init  = {{32{vys_q[31]}}, vys_q} << SHIFT;
    r_init   = {{32{rs_q[31]}}, rs_q} << SHIFT;
    acc_init = {{40{in_i.accel_cmd[ACCEL_W-1]}}, in_i.accel_cmd} << 8;
    str_init = {{46{in_i.steer_angle[STEER_W-1]}}, in_i.steer_angle} << 8;
    if (vx_init < SLOW_W) vx_init = LIFT_W;
    if (in_i.restart) begin
      vx_init  = RESTART_W;
      vy_init  = '0;
      r_init   = '0;
      acc_init = '0;
      str_init = '0;
    end
  end

  always_comb begin
    mul_req.start = (state_q == S_ISSUE) && (uc.op == OP_MUL);
    mul_req.a     = opa;
    mul_req.b     = opb;
    div_req.start = (state_q == S_ISSUE) && (uc.op == OP_DIV);
    div_req.a     = opa;
    div_req.b     = opb;
    cor_req.start = (state_q == S_ISSUE) && (uc.op == OP_ATAN || uc.op == OP_SINCOS);
    cor_req.rot   = (uc.op == OP_SINCOS);
    cor_req.a     = opa;
    cor_req.b     = opb;
  end

  bmtd_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  bmtd_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  bmtd_cordic u_cordic (.clk_i, .rst_ni, .req_i(cor_req), .rsp_o(cor_rsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= 24'd51200;
      inertia_q   <= 24'd51200;
      wb_q        <= 20'd98304;
      lf_q        <= 20'd49152;
      stiff_q     <= 28'd6400000;
      shape_q     <= 20'd91750;
      curv_q      <= '0;
      dt_q        <= 24'd167772;
      state_q     <= S_IDLE;
      pc_q        <= '0;
      vxs_q       <= '0;
      vys_q       <= '0;
      rs_q        <= '0;
      ovx_q       <= '0;
      ovy_q       <= '0;
      or_q        <= '0;
      out_valid_q <= 1'b0;
      accel_q     <= '0;
      steer_q     <= '0;
      mu_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      r_q         <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      slf_q       <= '0;
      slr_q       <= '0;
      fzf_q       <= '0;
      fzr_q       <= '0;
      d_q         <= '0;
      ba_q        <= '0;
      ff_q        <= '0;
      fr_q        <= '0;
      ffc_q       <= '0;
      sin_q       <= '0;
      cos_q       <= '0;
      dvx_q       <= '0;
      dvy_q       <= '0;
      dr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_MASS:      mass_q    <= cfg_data_i[23:0];
          CFG_INERTIA:   inertia_q <= cfg_data_i[23:0];
          CFG_WHEELBASE: wb_q      <= cfg_data_i[19:0];
          CFG_FRONT:     lf_q      <= cfg_data_i[19:0];
          CFG_STIFF:     stiff_q   <= cfg_data_i[27:0];
          CFG_SHAPE:     shape_q   <= cfg_data_i[19:0];
          CFG_CURV:      curv_q    <= cfg_data_i[20:0];
          CFG_DT:        dt_q      <= cfg_data_i[23:0];
          default: ;
        endcase
      end

      // in S_DONE the result register is reloaded below instead
      if (out_valid_q && out_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;

      if (wr_en) begin
        case (uc.d)
          DST_VX:  vx_q  <= wval;
          DST_VY:  vy_q  <= wval;
          DST_R:   r_q   <= wval;
          DST_T0:  t0_q  <= wval;
          DST_T1:  t1_q  <= wval;
          DST_SLF: slf_q <= wval;
          DST_SLR: slr_q <= wval;
          DST_FZF: fzf_q <= wval;
          DST_FZR: fzr_q <= wval;
          DST_D:   d_q   <= wval;
          DST_BA:  ba_q  <= wval;
          DST_FF:  ff_q  <= wval;
          DST_FR:  fr_q  <= wval;
          DST_FFC: ffc_q <= wval;
          DST_DVX: dvx_q <= wval;
          DST_DVY: dvy_q <= wval;
          DST_DR:  dr_q  <= wval;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            accel_q <= acc_init;
            steer_q <= str_init;
            mu_q    <= {38'd0, in_i.friction, 8'd0};
            vx_q    <= vx_init;
            vy_q    <= vy_init;
            r_q     <= r_init;
            pc_q    <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          case (uc.op)
            OP_ADD, OP_SUB: pc_q <= pc_q + 1'b1;
            OP_RND: begin
              case (uc.d)
                DST_VXS: vxs_q <= rnd32;
                DST_VYS: vys_q <= rnd32;
                DST_RS:  rs_q  <= rnd32;
                default: ;
              endcase
              pc_q <= pc_q + 1'b1;
            end
            OP_END:  state_q <= S_DONE;
            default: state_q <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (unit_done) begin
            if (uc.op == OP_SINCOS) begin
              sin_q <= cor_rsp.r0;
              cos_q <= cor_rsp.r1;
            end
            pc_q    <= pc_q + 1'b1;
            state_q <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            ovx_q       <= vxs_q;
            ovy_q       <= vys_q;
            or_q        <= rs_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.long_speed = ovx_q;
  assign out_o.lat_speed  = ovy_q;
  assign out_o.yaw_speed  = or_q;

  // only one shared unit is started at a time
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_req.start, div_req.start, cor_req.start}))
    else $error("more than one unit started");

  // unit results only come back while the sequencer waits for one
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_rsp.done || div_rsp.done || cor_rsp.done) |-> state_q == S_WAIT)
    else $error("unit result outside wait");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_ISSUE && pc_q == '0))
    else $error("accepted item did not start the program");

endmodule
